### rtl/tsrs_pkg.sv
// Package: beat types, field widths and controller states for the score retention select unit
`timescale 1ns / 1ps
`default_nettype none
package tsrs_pkg;

	localparam int IN_SCORE_W  = 16;
	localparam int POS_W       = 6;
	localparam int KEEP_W      = 7;
	localparam int MAX_RESULTS = 64;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd32;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic [IN_SCORE_W-1:0] score;
		logic                  last_sample;
	} score_beat_t;

	typedef struct packed {
		pos_t kept_position;
		logic last_kept;
	} kept_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EM_RD,
		ST_EM_CHK
	} ctrl_state_t;

endpackage
`default_nettype wire

### rtl/tsrs_mem.sv
// Simple dual-port sample memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module tsrs_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 23
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/tsrs_ctrl.sv
// Rank sweep and emit sequencer working read-modify-write on the sample memory
`timescale 1ns / 1ps
`default_nettype none
module tsrs_ctrl #(
	parameter int SAMPLE_SLOTS = 64,
	parameter int SCORE_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire tsrs_pkg::score_beat_t         in_beat,
	input  wire logic [tsrs_pkg::KEEP_W-1:0]   keep_count,
	output logic                               em_valid,
	input  wire logic                          em_ready,
	output tsrs_pkg::kept_beat_t               em_beat
);

	localparam int AW     = $clog2(SAMPLE_SLOTS);
	localparam int CNT_W  = $clog2(SAMPLE_SLOTS + 1);
	localparam int RANK_W = (AW < 1) ? 1 : AW;
	localparam int ENT_W  = SCORE_BITS + RANK_W;
	localparam int IN_W   = tsrs_pkg::IN_SCORE_W;
	localparam int KEEP_W = tsrs_pkg::KEEP_W;
	localparam int RES_W  = $clog2(tsrs_pkg::MAX_RESULTS + 1);
	localparam int CMP_W  = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

	tsrs_pkg::ctrl_state_t state_q, state_d;

	logic [CNT_W-1:0]      n_q, n_d;
	logic [CNT_W-1:0]      idx_q, idx_d;
	logic [RANK_W-1:0]     above_q, above_d;
	logic [RES_W-1:0]      em_cnt_q, em_cnt_d;
	logic [SCORE_BITS-1:0] score_q, score_d;
	logic                  last_q, last_d;
	logic                  v_s1, v_d;
	logic [AW-1:0]         addr_s1, addr_d;

	logic [SCORE_BITS-1:0] sat_score;
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [ENT_W-1:0]      mem_wdata, mem_rdata;
	logic [SCORE_BITS-1:0] rd_score;
	logic [RANK_W-1:0]     rd_rank;
	logic [CMP_W-1:0]      total;
	logic                  in_acc, have_room;

	generate
		if (SCORE_BITS >= IN_W) begin : g_wide
			assign sat_score = SCORE_BITS'(in_beat.score);
		end else begin : g_sat
			assign sat_score = (|in_beat.score[IN_W-1:SCORE_BITS]) ? '1 :
				in_beat.score[SCORE_BITS-1:0];
		end
	endgenerate

	assign rd_score  = mem_rdata[ENT_W-1:RANK_W];
	assign rd_rank   = mem_rdata[RANK_W-1:0];
	assign in_acc    = in_valid && !in_stall;
	assign have_room = n_q < CNT_W'(SAMPLE_SLOTS);

	always_comb begin
		total = CMP_W'(keep_count);
		if (CMP_W'(n_q) < total) begin
			total = CMP_W'(n_q);
		end
		if (CMP_W'(tsrs_pkg::MAX_RESULTS) < total) begin
			total = CMP_W'(tsrs_pkg::MAX_RESULTS);
		end
	end

	tsrs_mem #(
		.DEPTH(SAMPLE_SLOTS),
		.WIDTH(ENT_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tsrs_pkg::ST_IDLE;
			n_q      <= '0;
			idx_q    <= '0;
			above_q  <= '0;
			em_cnt_q <= '0;
			last_q   <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			state_q  <= state_d;
			n_q      <= n_d;
			idx_q    <= idx_d;
			above_q  <= above_d;
			em_cnt_q <= em_cnt_d;
			last_q   <= last_d;
			v_s1     <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		score_q <= score_d;
		addr_s1 <= addr_d;
	end

	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		idx_d     = idx_q;
		above_d   = above_q;
		em_cnt_d  = em_cnt_q;
		score_d   = score_q;
		last_d    = last_q;
		v_d       = 1'b0;
		addr_d    = idx_q[AW-1:0];
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = {rd_score, rd_rank + RANK_W'(1)};
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		em_valid  = 1'b0;
		em_beat.kept_position = tsrs_pkg::pos_t'(idx_q);
		em_beat.last_kept     = (CMP_W'(em_cnt_q) + CMP_W'(1)) == total;
		case (state_q)
			tsrs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_acc) begin
					score_d = sat_score;
					last_d  = in_beat.last_sample;
					idx_d   = '0;
					above_d = '0;
					if (have_room) begin
						state_d = tsrs_pkg::ST_SWEEP;
					end else if (in_beat.last_sample) begin
						em_cnt_d = '0;
						state_d  = tsrs_pkg::ST_EM_RD;
					end
				end
			end
			tsrs_pkg::ST_SWEEP: begin
				if (idx_q < n_q) begin
					mem_re = 1'b1;
					v_d    = 1'b1;
					idx_d  = idx_q + CNT_W'(1);
				end
				if (v_s1) begin
					if (rd_score >= score_q) begin
						above_d = above_q + RANK_W'(1);
					end else begin
						mem_we = 1'b1;
					end
				end else if (!(idx_q < n_q)) begin
					mem_we    = 1'b1;
					mem_waddr = n_q[AW-1:0];
					mem_wdata = {score_q, above_q};
					n_d       = n_q + CNT_W'(1);
					idx_d     = '0;
					em_cnt_d  = '0;
					state_d   = last_q ? tsrs_pkg::ST_EM_RD : tsrs_pkg::ST_IDLE;
				end
			end
			tsrs_pkg::ST_EM_RD: begin
				if (idx_q == n_q || CMP_W'(em_cnt_q) == total) begin
					n_d     = '0;
					state_d = tsrs_pkg::ST_IDLE;
				end else begin
					mem_re  = 1'b1;
					state_d = tsrs_pkg::ST_EM_CHK;
				end
			end
			tsrs_pkg::ST_EM_CHK: begin
				if (CMP_W'(rd_rank) < CMP_W'(keep_count)) begin
					em_valid = 1'b1;
					if (em_ready) begin
						em_cnt_d = em_cnt_q + RES_W'(1);
						idx_d    = idx_q + CNT_W'(1);
						state_d  = tsrs_pkg::ST_EM_RD;
					end
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = tsrs_pkg::ST_EM_RD;
				end
			end
			default: begin
				state_d = tsrs_pkg::ST_IDLE;
			end
		endcase
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(SAMPLE_SLOTS))
		else $error("sample count overran the memory");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsrs_pkg::ST_EM_CHK) |-> (CMP_W'(em_cnt_q) < total))
		else $error("emit went past the kept count");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(em_valid && em_ready && em_beat.last_kept) |=>
			(state_q == tsrs_pkg::ST_EM_RD && CMP_W'(em_cnt_q) == total))
		else $error("run did not end after the final kept beat");

endmodule
`default_nettype wire

### rtl/top_score_retention_select_unit.sv
// Top level: keep count register, rank/emit controller and output register
//
// Usage:
//   Input channel (in_valid/in_stall/in_beat) takes one score beat per stored
//   sample in memory order; last_sample marks the final sample of a set.
//   After the last sample the output channel (out_valid/out_stall/out_beat)
//   delivers the positions of the keep_count highest scores in ascending
//   position order; last_kept marks the final position of the run.
//   keep_count is written through cfg_we/cfg_wdata while the unit is idle.
// Timing:
//   A score beat arriving with n samples stored is handled in the controller as
//   n reads of the sample memory to update the stored ranks, a drain of the
//   read pipeline and a write of the new entry (only the write when none is stored).
//   The single read port of the memory forces the n reads to run one after another.
//   The emit pass reads and then checks each stored position up to the last kept one,
//   finishes in the read state, and holds while a kept beat is stalled.
//   The output register lets the next set start while the last beat waits.
// Reset:
//   arst_n clears the sample count, the controller and the output valid;
//   keep_count returns to 32. The memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module top_score_retention_select_unit #(
	parameter int SAMPLE_SLOTS = 64,
	parameter int SCORE_BITS   = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire tsrs_pkg::score_beat_t       in_beat,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output tsrs_pkg::kept_beat_t             out_beat,
	input  wire logic                        cfg_we,
	input  wire logic [tsrs_pkg::KEEP_W-1:0] cfg_wdata
);

	logic [tsrs_pkg::KEEP_W-1:0] keep_q;
	logic                        em_valid, em_ready;
	tsrs_pkg::kept_beat_t        em_beat;
	logic                        out_valid_q;
	tsrs_pkg::kept_beat_t        out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= tsrs_pkg::KEEP_RESET;
		end else if (cfg_we) begin
			keep_q <= cfg_wdata;
		end
	end

	tsrs_ctrl #(
		.SAMPLE_SLOTS(SAMPLE_SLOTS),
		.SCORE_BITS  (SCORE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.keep_count(keep_q),
		.em_valid  (em_valid),
		.em_ready  (em_ready),
		.em_beat   (em_beat)
	);

	assign em_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (em_ready) begin
			out_valid_q <= em_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (em_valid && em_ready) begin
			out_q <= em_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for the score retention select unit: directed table, random sets, rank predictor
`timescale 1ns / 1ps
module tb_top;
	import tsrs_pkg::*;

	localparam int SAMPLE_SLOTS   = 64;
	localparam int HOLD_OFF       = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DIR_ROWS       = 25;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PRED,
		ROW_TYPED
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [KEEP_W-1:0] keep;
		logic [15:0]       score;
		logic              last;
		logic [1:0]        n_exp;
		pos_t              pos0;
		pos_t              pos1;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	score_beat_t       in_beat   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	kept_beat_t        out_beat;
	logic              cfg_we    = 1'b0;
	logic [KEEP_W-1:0] cfg_wdata = '0;

	top_score_retention_select_unit #(
		.SAMPLE_SLOTS(SAMPLE_SLOTS),
		.SCORE_BITS  (16)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat (out_beat),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	logic [15:0]       held_score [SAMPLE_SLOTS];
	logic [KEEP_W-1:0] outrank    [SAMPLE_SLOTS];
	int                loaded_samples;
	logic [KEEP_W-1:0] keep_reg;
	kept_beat_t        sel_buf [MAX_RESULTS];
	kept_beat_t        kept_q [$];

	int errors     = 0;
	int n_items    = 0;
	int n_sets     = 0;
	int n_kept     = 0;
	int n_cfg      = 0;
	int src_pct    = 0;
	int sink_pct   = 0;
	int quiet_cyc  = 0;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{ROW_TYPED, 7'd0,   16'h0000, 1'b1, 2'd1, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'hFFFF, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_TYPED, 7'd0,   16'h0000, 1'b1, 2'd2, 6'd0, 6'd1},
		'{ROW_CFG,   7'd1,   16'h0000, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h0000, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_TYPED, 7'd0,   16'hFFFF, 1'b1, 2'd1, 6'd1, 6'd0},
		'{ROW_PRED,  7'd0,   16'h0005, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_TYPED, 7'd0,   16'h0005, 1'b1, 2'd1, 6'd0, 6'd0},
		'{ROW_CFG,   7'd0,   16'h0000, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h1234, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_TYPED, 7'd0,   16'hFFFF, 1'b1, 2'd0, 6'd0, 6'd0},
		'{ROW_CFG,   7'd64,  16'h0000, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'hAAAA, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h5555, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'hFFFF, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h0001, 1'b1, 2'd0, 6'd0, 6'd0},
		'{ROW_CFG,   7'd127, 16'h0000, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h8000, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h7FFF, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h8000, 1'b1, 2'd0, 6'd0, 6'd0},
		'{ROW_CFG,   7'd2,   16'h0000, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h0100, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_PRED,  7'd0,   16'h0100, 1'b0, 2'd0, 6'd0, 6'd0},
		'{ROW_TYPED, 7'd0,   16'h0100, 1'b1, 2'd2, 6'd0, 6'd1},
		'{ROW_CFG,   7'd32,  16'h0000, 1'b0, 2'd0, 6'd0, 6'd0}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 200) begin
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	function automatic int rank_select(input score_beat_t b);
		int               sel;
		int               i;
		logic [KEEP_W-1:0] above;
		sel = 0;
		if (loaded_samples < SAMPLE_SLOTS) begin
			above = '0;
			for (i = 0; i < loaded_samples; i++) begin
				if (held_score[i] >= b.score) begin
					above++;
				end else begin
					outrank[i]++;
				end
			end
			held_score[loaded_samples] = b.score;
			outrank[loaded_samples]    = above;
			loaded_samples++;
		end
		if (!b.last_sample) begin
			return 0;
		end
		for (i = 0; i < loaded_samples; i++) begin
			if (sel < MAX_RESULTS && outrank[i] < keep_reg) begin
				sel_buf[sel].kept_position = i[POS_W-1:0];
				sel_buf[sel].last_kept     = 1'b0;
				sel++;
			end
		end
		if (sel > 0) begin
			sel_buf[sel-1].last_kept = 1'b1;
		end
		loaded_samples = 0;
		return sel;
	endfunction

	task automatic drive_score(input score_beat_t b, output int n_sel);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_beat  <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (loaded_samples < SAMPLE_SLOTS) begin
			n_items++;
		end
		if (b.last_sample) begin
			n_sets++;
		end
		n_sel = rank_select(b);
	endtask

	task automatic push_selection(input int n_sel);
		int i;
		for (i = 0; i < n_sel; i++) begin
			kept_q.push_back(sel_buf[i]);
		end
	endtask

	task automatic drain_kept();
		@(negedge clk);
		in_valid <= 1'b0;
		while (kept_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic settle_idle();
		drain_kept();
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic write_keep(input logic [KEEP_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		keep_reg = v;
		n_cfg++;
	endtask

	task automatic send_set(input int len, input int flavor);
		score_beat_t b;
		int          n_sel;
		int          i;
		for (i = 0; i < len; i++) begin
			case (flavor)
				0: b.score = 16'($urandom_range(0, 65535));
				1: b.score = 16'($urandom_range(0, 3) * 32'h5555);
				default: b.score = 16'($urandom_range(0, 7));
			endcase
			b.last_sample = (i == len - 1);
			drive_score(b, n_sel);
			push_selection(n_sel);
		end
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_kept++;
			if (kept_q.size() == 0) begin
				report_mismatch("kept beat with nothing expected", out_beat.kept_position, -1);
			end else begin
				if (out_beat.kept_position !== kept_q[0].kept_position) begin
					report_mismatch("kept_position", out_beat.kept_position,
						kept_q[0].kept_position);
				end
				if (out_beat.last_kept !== kept_q[0].last_kept) begin
					report_mismatch("last_kept", out_beat.last_kept, kept_q[0].last_kept);
				end
				void'(kept_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cyc <= 0;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
			if (quiet_cyc + 1 >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int          r;
		int          ph;
		int          n_sel;
		int          items_ph;
		int          sets_ph;
		int          len;
		score_beat_t b;
		pos_t        exp_pos [2];
		kept_beat_t  kb;

		arst_n         = 1'b0;
		loaded_samples = 0;
		keep_reg       = KEEP_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				settle_idle();
				write_keep(dir_rows[r].keep);
			end else begin
				b.score       = dir_rows[r].score;
				b.last_sample = dir_rows[r].last;
				drive_score(b, n_sel);
				if (dir_rows[r].kind == ROW_TYPED) begin
					exp_pos[0] = dir_rows[r].pos0;
					exp_pos[1] = dir_rows[r].pos1;
					for (int k = 0; k < dir_rows[r].n_exp; k++) begin
						kb.kept_position = exp_pos[k];
						kb.last_kept     = (k == dir_rows[r].n_exp - 1);
						kept_q.push_back(kb);
					end
				end else begin
					push_selection(n_sel);
				end
			end
		end

		for (ph = 0; ph < 4; ph++) begin
			drain_kept();
			case (ph)
				0: begin src_pct = 0;  sink_pct = 0;  end
				1: begin src_pct = 77; sink_pct = 0;  end
				2: begin src_pct = 0;  sink_pct = 77; end
				default: begin src_pct = 32; sink_pct = 32; end
			endcase
			items_ph = 0;
			sets_ph  = 0;
			if (ph == 0 || ph == 3) begin
				settle_idle();
				write_keep(ph == 0 ? 7'd127 : 7'($urandom_range(0, 127)));
				len = $urandom_range(65, 70);
				send_set(len, $urandom_range(0, 2));
				items_ph += len;
			end
			if (ph == 2) begin
				send_set(SAMPLE_SLOTS, 0);
				items_ph += SAMPLE_SLOTS;
			end
			while (items_ph < 110) begin
				if (sets_ph % 3 == 0) begin
					settle_idle();
					case ($urandom_range(0, 7))
						0: write_keep(7'd0);
						1: write_keep(7'd1);
						2: write_keep(7'd64);
						3: write_keep(7'd127);
						4, 5: write_keep(7'($urandom_range(1, 16)));
						6: write_keep(7'($urandom_range(17, 64)));
						default: write_keep(7'($urandom_range(65, 126)));
					endcase
				end
				len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
				send_set(len, $urandom_range(0, 2));
				items_ph += len;
				sets_ph++;
			end
		end

		drain_kept();
		repeat (HOLD_OFF) @(posedge clk);
		if (kept_q.size() != 0) begin
			report_mismatch("kept beats never delivered", 0, kept_q.size());
		end

		$display("Run covered %0d sets with %0d stored score beats, %0d kept beats checked,",
			n_sets, n_items, n_kept);
		$display("%0d keep_count writes (0, 1, 64, 127 and random) under four idle patterns",
			n_cfg);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
